/* rtl/pop3_login_credential_sniffer_assert.svh */
// ----------------------------------------------------------------------------
// POP3 credential sniffer assertion macros
// Concurrent assertion shorthands, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef POP3_LOGIN_CREDENTIAL_SNIFFER_ASSERT_SVH
`define POP3_LOGIN_CREDENTIAL_SNIFFER_ASSERT_SVH

// same-cycle implication
`define POP3CS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pop3cs: same-cycle check failed");

// next-cycle implication
`define POP3CS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pop3cs: next-cycle check failed");

`endif

/* rtl/pop3cs_pkg.sv */
// ----------------------------------------------------------------------------
// pop3cs_pkg
// Types, character constants and limits shared by the credential sniffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pop3cs_pkg;

	localparam logic [7:0] MAX_FIELD_LEN = 8'd64;

	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [4:0] {
		S_START    = 5'd0,
		S_SKIP     = 5'd1,
		S_U        = 5'd2,
		S_US       = 5'd3,
		S_USE      = 5'd4,
		S_USER     = 5'd5,
		S_USER_SP  = 5'd6,
		S_NAME     = 5'd7,
		S_NAME_END = 5'd8,
		S_U_PLUS   = 5'd9,
		S_U_ERR    = 5'd10,
		S_U_O      = 5'd11,
		S_U_K      = 5'd12,
		S_U_SP     = 5'd13,
		S_U_OKEND  = 5'd14,
		S_P        = 5'd15,
		S_PA       = 5'd16,
		S_PAS      = 5'd17,
		S_PASS     = 5'd18,
		S_PASS_SP  = 5'd19,
		S_PWD      = 5'd20,
		S_PWD_END  = 5'd21,
		S_P_PLUS   = 5'd22,
		S_P_ERR    = 5'd23,
		S_P_O      = 5'd24,
		S_DONE     = 5'd25
	} state_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_UBYTE  = 3'd1,
		EV_UEND   = 3'd2,
		EV_UERASE = 3'd3,
		EV_PBYTE  = 3'd4,
		EV_PEND   = 3'd5,
		EV_PERASE = 3'd6,
		EV_FIN    = 3'd7
	} event_t;

	// advance on the wanted byte, restart on newline, else skip the line
	function automatic state_t match_next(input logic [7:0] c, input logic [7:0] want,
		input state_t nxt);
		state_t r;
		if (c == want) begin
			r = nxt;
		end else if (c == CH_LF) begin
			r = S_START;
		end else begin
			r = S_SKIP;
		end
		return r;
	endfunction

endpackage

/* rtl/pop3cs_step.sv */
// ----------------------------------------------------------------------------
// pop3cs_step
// Transition and event decode for one byte of the POP3 login parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pop3cs_step (
	input  pop3cs_pkg::state_t cur_state,
	input  logic [7:0]         byte_val,
	output pop3cs_pkg::state_t nxt_state,
	output pop3cs_pkg::event_t ev
);
	import pop3cs_pkg::*;

	logic nl;

	assign nl = (byte_val == CH_LF);

	always_comb begin
		nxt_state = cur_state;
		if (byte_val != CH_NUL) begin
			case (cur_state)
				S_SKIP:     nxt_state = nl ? S_START : S_SKIP;
				S_U:        nxt_state = match_next(byte_val, CH_S, S_US);
				S_US:       nxt_state = match_next(byte_val, CH_E, S_USE);
				S_USE:      nxt_state = match_next(byte_val, CH_R, S_USER);
				S_USER:     nxt_state = match_next(byte_val, CH_SPACE, S_USER_SP);
				S_USER_SP:  nxt_state = nl ? S_START : S_NAME;
				S_NAME:     nxt_state = nl ? S_NAME_END : S_NAME;
				S_NAME_END: begin
					if (byte_val == CH_PLUS) begin
						nxt_state = S_U_PLUS;
					end else if (byte_val == CH_MINUS) begin
						nxt_state = S_U_ERR;
					end else begin
						nxt_state = nl ? S_START : S_SKIP;
					end
				end
				S_U_ERR:    nxt_state = nl ? S_START : S_SKIP;
				S_U_PLUS:   nxt_state = match_next(byte_val, CH_O, S_U_O);
				S_U_O:      nxt_state = match_next(byte_val, CH_K, S_U_K);
				S_U_K:      nxt_state = match_next(byte_val, CH_SPACE, S_U_SP);
				S_U_SP:     nxt_state = S_U_OKEND;
				S_U_OKEND:  nxt_state = match_next(byte_val, CH_P, S_P);
				S_P:        nxt_state = match_next(byte_val, CH_A, S_PA);
				S_PA:       nxt_state = match_next(byte_val, CH_S, S_PAS);
				S_PAS:      nxt_state = match_next(byte_val, CH_S, S_PASS);
				S_PASS:     nxt_state = match_next(byte_val, CH_SPACE, S_PASS_SP);
				S_PASS_SP:  nxt_state = nl ? S_START : S_PWD;
				S_PWD:      nxt_state = nl ? S_PWD_END : S_PWD;
				S_PWD_END: begin
					if (byte_val == CH_PLUS) begin
						nxt_state = S_P_PLUS;
					end else if (byte_val == CH_MINUS) begin
						nxt_state = S_P_ERR;
					end else begin
						nxt_state = nl ? S_START : S_SKIP;
					end
				end
				S_P_ERR:    nxt_state = nl ? S_START : S_SKIP;
				S_P_PLUS:   nxt_state = match_next(byte_val, CH_O, S_P_O);
				S_P_O:      nxt_state = match_next(byte_val, CH_K, S_DONE);
				S_DONE:     nxt_state = S_DONE;
				default:    nxt_state = (byte_val == CH_U) ? S_U : S_SKIP;
			endcase
		end
	end

	always_comb begin
		ev = EV_NONE;
		if (byte_val != CH_NUL) begin
			case (cur_state)
				S_USER_SP:  ev = nl ? EV_NONE : EV_UBYTE;
				S_NAME:     ev = nl ? EV_UEND : EV_UBYTE;
				S_NAME_END: ev = (byte_val == CH_MINUS) ? EV_UERASE : EV_NONE;
				S_PASS_SP:  ev = nl ? EV_NONE : EV_PBYTE;
				S_PWD:      ev = nl ? EV_PEND : EV_PBYTE;
				S_PWD_END:  ev = (byte_val == CH_MINUS) ? EV_PERASE : EV_NONE;
				S_DONE:     ev = EV_FIN;
				default:    ev = EV_NONE;
			endcase
		end
	end

endmodule

/* rtl/pop3_login_credential_sniffer.sv */
// ----------------------------------------------------------------------------
// pop3_login_credential_sniffer
// Byte-wide POP3 USER/PASS capture with per-byte event output.
// ----------------------------------------------------------------------------
// One byte per transfer in, one event per byte out, at a sustained rate of
// one byte per clock while event_stall stays low. The byte is registered,
// then the parser state, username/password length counters and the event
// register are all updated from that byte once the event register can take
// it. The state and counter recurrence closes through those registers alone,
// which sets the one-byte-per-clock rate. Input stall rises only while the
// input register is full and the event register is stalled.
`timescale 1ns / 1ps

module pop3_login_credential_sniffer #(
	parameter logic [7:0] FIELD_LIMIT = pop3cs_pkg::MAX_FIELD_LEN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       event_valid,
	input  logic       event_stall,
	output logic [2:0] event_code,
	output logic [7:0] event_byte,
	output logic [6:0] field_position,
	output logic       field_overflow
);
	import pop3cs_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	event_t     code_s2;
	logic [7:0] byte_s2;
	logic [6:0] pos_s2;
	logic       ovf_s2;

	state_t     state_q;
	logic [6:0] user_cnt_q;
	logic [6:0] pass_cnt_q;

	state_t     state_nxt;
	event_t     ev;
	logic       s2_ready;
	logic       load;
	logic       user_full;
	logic       pass_full;
	logic [6:0] pos;
	logic       ovf;

	pop3cs_step u_step (
		.cur_state  (state_q),
		.byte_val   (byte_s1),
		.nxt_state  (state_nxt),
		.ev         (ev)
	);

	assign s2_ready = !valid_s2 || !event_stall;
	assign rx_stall = valid_s1 && !s2_ready;
	assign load     = valid_s1 && s2_ready;

	assign user_full = ({1'b0, user_cnt_q} >= FIELD_LIMIT);
	assign pass_full = ({1'b0, pass_cnt_q} >= FIELD_LIMIT);

	always_comb begin
		pos = 7'd0;
		ovf = 1'b0;
		case (ev)
			EV_UBYTE: begin
				pos = user_cnt_q;
				ovf = user_full;
			end
			EV_UEND, EV_UERASE: pos = user_cnt_q;
			EV_PBYTE: begin
				pos = pass_cnt_q;
				ovf = pass_full;
			end
			EV_PEND, EV_PERASE: pos = pass_cnt_q;
			default: pos = 7'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			state_q    <= S_START;
			user_cnt_q <= 7'd0;
			pass_cnt_q <= 7'd0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (load) begin
				state_q <= state_nxt;
				case (ev)
					EV_UBYTE:  if (!user_full) user_cnt_q <= user_cnt_q + 7'd1;
					EV_UERASE: user_cnt_q <= 7'd0;
					EV_PBYTE:  if (!pass_full) pass_cnt_q <= pass_cnt_q + 7'd1;
					EV_PERASE: pass_cnt_q <= 7'd0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_s2 <= ev;
			byte_s2 <= byte_s1;
			pos_s2  <= pos;
			ovf_s2  <= ovf;
		end
	end

	assign event_valid    = valid_s2;
	assign event_code     = code_s2;
	assign event_byte     = byte_s2;
	assign field_position = pos_s2;
	assign field_overflow = ovf_s2;

`include "pop3_login_credential_sniffer_assert.svh"

	`POP3CS_ASSERT_NOW(a_ovf_only_on_byte, valid_s2 && ovf_s2,
		code_s2 == EV_UBYTE || code_s2 == EV_PBYTE)
	`POP3CS_ASSERT_NOW(a_no_pos_without_field, valid_s2 && (code_s2 == EV_NONE || code_s2 == EV_FIN),
		pos_s2 == 7'd0)
	`POP3CS_ASSERT_NEXT(a_done_sticks, state_q == S_DONE, state_q == S_DONE)
	`POP3CS_ASSERT_NEXT(a_user_erase_clears, load && ev == EV_UERASE, user_cnt_q == 7'd0)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the POP3 login credential sniffer.
// ----------------------------------------------------------------------------
// A short scripted login opens the run, then random sessions follow: mostly
// USER/PASS exchanges with random names, secrets and replies, mixed with noise
// lines, cut-off keywords and stray zero bytes. One full login at the end puts
// the parser into its finished state. Every byte offered is run through a
// local copy of the parser, and each event the block hands out is compared
// field by field with the oldest expected event.

module tb;
	import pop3cs_pkg::*;

	typedef struct packed {
		event_t     code;
		logic [7:0] data;
		logic [6:0] pos;
		logic       ovf;
	} sniff_ev_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		event_t     code;
		logic [6:0] pos;
		logic       ovf;
	} script_row_t;

	localparam int SCRIPT_LEN = 25;
	localparam int RANDOM_BYTES = 700;

	// scripted opening; typed rows carry their own expected event
	localparam script_row_t LOGIN_SCRIPT [SCRIPT_LEN] = '{
		'{CH_NUL,   1'b1, EV_NONE,   7'd0, 1'b0},
		'{8'hFF,    1'b1, EV_NONE,   7'd0, 1'b0},
		'{CH_LF,    1'b1, EV_NONE,   7'd0, 1'b0},
		'{CH_U,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_S,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_E,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_R,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_SPACE, 1'b0, EV_NONE,   7'd0, 1'b0},
		'{8'h80,    1'b1, EV_UBYTE,  7'd0, 1'b0},
		'{CH_NUL,   1'b1, EV_NONE,   7'd0, 1'b0},
		'{CH_LF,    1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_PLUS,  1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_O,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_K,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_SPACE, 1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_LF,    1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_P,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_A,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_S,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_S,     1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_SPACE, 1'b0, EV_NONE,   7'd0, 1'b0},
		'{8'hFF,    1'b1, EV_PBYTE,  7'd0, 1'b0},
		'{CH_LF,    1'b0, EV_NONE,   7'd0, 1'b0},
		'{CH_MINUS, 1'b1, EV_PERASE, 7'd1, 1'b0},
		'{CH_LF,    1'b0, EV_NONE,   7'd0, 1'b0}
	};

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       event_valid;
	logic       event_stall;
	logic [2:0] event_code;
	logic [7:0] event_byte;
	logic [6:0] field_position;
	logic       field_overflow;

	sniff_ev_t  pending_events[$];
	state_t     model_state;
	logic [6:0] model_user_len;
	logic [6:0] model_pass_len;
	int         sent;
	int         checked;
	int         fails;
	int         saturated;
	int         hits[8];
	logic       quiet;
	logic       hold_req;
	sniff_ev_t  got_ev;
	sniff_ev_t  want_ev;

	pop3_login_credential_sniffer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.event_code    (event_code),
		.event_byte    (event_byte),
		.field_position(field_position),
		.field_overflow(field_overflow)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic state_t next_if(input logic [7:0] c, input logic [7:0] want,
		input state_t hit);
		if (c == want) return hit;
		return (c == CH_LF) ? S_START : S_SKIP;
	endfunction

	// parser step: advances the local state and counters, returns the event
	task automatic sniff_predict(input logic [7:0] c, output sniff_ev_t r);
		state_t nx;
		event_t ev;
		logic [6:0] pos;
		logic ovf;
		logic lf;
		nx = model_state;
		ev = EV_NONE;
		pos = 7'd0;
		ovf = 1'b0;
		lf = (c == CH_LF);
		if (c != CH_NUL) begin
			case (model_state)
			S_SKIP:     nx = lf ? S_START : S_SKIP;
			S_U:        nx = next_if(c, CH_S, S_US);
			S_US:       nx = next_if(c, CH_E, S_USE);
			S_USE:      nx = next_if(c, CH_R, S_USER);
			S_USER:     nx = next_if(c, CH_SPACE, S_USER_SP);
			S_USER_SP, S_NAME: begin
				if (lf) begin
					nx = (model_state == S_NAME) ? S_NAME_END : S_START;
					ev = (model_state == S_NAME) ? EV_UEND : EV_NONE;
				end else begin
					nx = S_NAME;
					ev = EV_UBYTE;
				end
			end
			S_NAME_END: begin
				if (c == CH_PLUS) begin
					nx = S_U_PLUS;
				end else if (c == CH_MINUS) begin
					nx = S_U_ERR;
					ev = EV_UERASE;
				end else begin
					nx = lf ? S_START : S_SKIP;
				end
			end
			S_U_ERR:    nx = lf ? S_START : S_SKIP;
			S_U_PLUS:   nx = next_if(c, CH_O, S_U_O);
			S_U_O:      nx = next_if(c, CH_K, S_U_K);
			S_U_K:      nx = next_if(c, CH_SPACE, S_U_SP);
			S_U_SP:     nx = S_U_OKEND;
			S_U_OKEND:  nx = next_if(c, CH_P, S_P);
			S_P:        nx = next_if(c, CH_A, S_PA);
			S_PA:       nx = next_if(c, CH_S, S_PAS);
			S_PAS:      nx = next_if(c, CH_S, S_PASS);
			S_PASS:     nx = next_if(c, CH_SPACE, S_PASS_SP);
			S_PASS_SP, S_PWD: begin
				if (lf) begin
					nx = (model_state == S_PWD) ? S_PWD_END : S_START;
					ev = (model_state == S_PWD) ? EV_PEND : EV_NONE;
				end else begin
					nx = S_PWD;
					ev = EV_PBYTE;
				end
			end
			S_PWD_END: begin
				if (c == CH_PLUS) begin
					nx = S_P_PLUS;
				end else if (c == CH_MINUS) begin
					nx = S_P_ERR;
					ev = EV_PERASE;
				end else begin
					nx = lf ? S_START : S_SKIP;
				end
			end
			S_P_ERR:    nx = lf ? S_START : S_SKIP;
			S_P_PLUS:   nx = next_if(c, CH_O, S_P_O);
			S_P_O:      nx = next_if(c, CH_K, S_DONE);
			S_DONE: begin
				nx = S_DONE;
				ev = EV_FIN;
			end
			default:    nx = (c == CH_U) ? S_U : S_SKIP;
			endcase
		end
		case (ev)
		EV_UBYTE: begin
			pos = model_user_len;
			if (model_user_len < MAX_FIELD_LEN) model_user_len = model_user_len + 7'd1;
			else ovf = 1'b1;
		end
		EV_UEND:   pos = model_user_len;
		EV_UERASE: begin
			pos = model_user_len;
			model_user_len = 7'd0;
		end
		EV_PBYTE: begin
			pos = model_pass_len;
			if (model_pass_len < MAX_FIELD_LEN) model_pass_len = model_pass_len + 7'd1;
			else ovf = 1'b1;
		end
		EV_PEND:   pos = model_pass_len;
		EV_PERASE: begin
			pos = model_pass_len;
			model_pass_len = 7'd0;
		end
		default: ;
		endcase
		model_state = nx;
		r = '{code: ev, data: c, pos: pos, ovf: ovf};
	endtask

	// entered and left at a falling edge; valid stays up between back-to-back bytes
	task automatic send_byte(input logic [7:0] b, input logic typed, input sniff_ev_t typed_ev);
		sniff_ev_t pred;
		while (!quiet && $urandom_range(0, 99) < 11) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		sniff_predict(b, pred);
		pending_events.push_back(typed ? typed_ev : pred);
		sent++;
		@(negedge clk);
	endtask

	// occasional zero byte ahead of the real one
	task automatic put_byte(input logic [7:0] b);
		if ($urandom_range(0, 24) == 0) send_byte(CH_NUL, 1'b0, '0);
		send_byte(b, 1'b0, '0);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
		return b;
	endfunction

	function automatic int field_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
	endfunction

	task automatic send_word(input string w);
		for (int i = 0; i < w.len(); i++) put_byte(w[i]);
	endtask

	task automatic send_text(input int n);
		repeat (n) put_byte(text_byte());
	endtask

	task automatic noise_line();
		repeat ($urandom_range(0, 20)) put_byte(8'($urandom_range(1, 255)));
		put_byte(CH_LF);
	endtask

	task automatic broken_keyword();
		string w;
		w = ($urandom_range(0, 1) != 0) ? "USER " : "PASS ";
		for (int i = 0; i < $urandom_range(0, 4); i++) put_byte(w[i]);
		if ($urandom_range(0, 1) != 0) put_byte(text_byte());
		put_byte(CH_LF);
	endtask

	task automatic login_attempt();
		int pick;
		logic [7:0] b;
		send_word("USER ");
		send_text(field_len());
		put_byte(CH_LF);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			put_byte(CH_MINUS);
			send_text($urandom_range(0, 6));
			put_byte(CH_LF);
		end else if (pick < 32) begin
			noise_line();
		end else if (pick < 40) begin
			send_word("+O");
			do b = text_byte(); while (b == CH_K);
			put_byte(b);
			put_byte(CH_LF);
		end else begin
			send_word("+OK ");
			put_byte(($urandom_range(0, 1) != 0) ? CH_LF : text_byte());
			if ($urandom_range(0, 99) < 12) begin
				broken_keyword();
			end else begin
				send_word("PASS ");
				send_text(field_len());
				put_byte(CH_LF);
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					put_byte(CH_MINUS);
					send_text($urandom_range(0, 6));
					put_byte(CH_LF);
				end else if (pick < 80) begin
					put_byte(CH_PLUS);
					do b = text_byte(); while (b == CH_O);
					put_byte(b);
					put_byte(CH_LF);
				end else begin
					send_word("+O");
					do b = text_byte(); while (b == CH_K);
					put_byte(b);
					put_byte(CH_LF);
				end
			end
		end
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		while (pending_events.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// event checker
	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall) begin
			got_ev = '{code: event_t'(event_code), data: event_byte, pos: field_position,
				ovf: field_overflow};
			if (pending_events.size() == 0) begin
				if (fails < 10)
					$display("unexpected event at %0t: code %0d byte %h pos %0d ovf %0d",
						$realtime, got_ev.code, got_ev.data, got_ev.pos, got_ev.ovf);
				fails++;
			end else begin
				want_ev = pending_events.pop_front();
				checked++;
				hits[event_code]++;
				if (field_overflow) saturated++;
				if (got_ev.code !== want_ev.code || got_ev.data !== want_ev.data ||
					got_ev.pos !== want_ev.pos || got_ev.ovf !== want_ev.ovf) begin
					if (fails < 10)
						$display({"mismatch at %0t: expected code %0d byte %h pos %0d ovf %0d,",
							" got code %0d byte %h pos %0d ovf %0d"}, $realtime,
							want_ev.code, want_ev.data, want_ev.pos, want_ev.ovf,
							got_ev.code, got_ev.data, got_ev.pos, got_ev.ovf);
					fails++;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		event_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				event_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
				event_stall <= 1'b0;
			end else begin
				event_stall <= !quiet && ($urandom_range(0, 99) < 11);
			end
		end
	end

	initial begin
		int pick;
		logic hold_done;
		sniff_ev_t typed_ev;
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		sent = 0;
		checked = 0;
		fails = 0;
		saturated = 0;
		foreach (hits[i]) hits[i] = 0;
		model_state = S_START;
		model_user_len = 7'd0;
		model_pass_len = 7'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			typed_ev = '{code: LOGIN_SCRIPT[i].code, data: LOGIN_SCRIPT[i].b,
				pos: LOGIN_SCRIPT[i].pos, ovf: LOGIN_SCRIPT[i].ovf};
			send_byte(LOGIN_SCRIPT[i].b, LOGIN_SCRIPT[i].typed, typed_ev);
		end
		drain();

		while (sent < RANDOM_BYTES) begin
			if (sent >= 150 && !hold_done) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			quiet = (sent >= 350 && sent < 480);
			pick = $urandom_range(0, 99);
			if (pick < 65) login_attempt();
			else if (pick < 85) noise_line();
			else broken_keyword();
		end
		quiet = 1'b0;
		drain();

		// complete login, then the parser sits in its finished state
		send_word("USER ");
		send_text(5);
		put_byte(CH_LF);
		send_word("+OK ");
		put_byte(CH_LF);
		send_word("PASS ");
		send_text(6);
		put_byte(CH_LF);
		send_word("+OK");
		send_byte(8'hFF, 1'b0, '0);
		repeat (12) put_byte(8'($urandom_range(0, 255)));
		drain();
		repeat (8) @(posedge clk);

		fails += pending_events.size();
		$display("run: %0d bytes sent, %0d events checked, %0d saturated field bytes",
			sent, checked, saturated);
		$display("events: user %0d/%0d/%0d, pass %0d/%0d/%0d, finished %0d, none %0d",
			hits[EV_UBYTE], hits[EV_UEND], hits[EV_UERASE], hits[EV_PBYTE],
			hits[EV_PEND], hits[EV_PERASE], hits[EV_FIN], hits[EV_NONE]);
		if (fails == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
